FILE: hdl/tcpg_pkg.sv
`timescale 1ns / 1ps

package tcpg_pkg;

  typedef enum logic [1:0] {
    REG_FONT_WIDTH     = 2'd0,
    REG_FONT_HEIGHT    = 2'd1,
    REG_SURFACE_WIDTH  = 2'd2,
    REG_SURFACE_HEIGHT = 2'd3
  } reg_idx_e;

  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [7:0]  ATTR_UNDERLINE = 8'h02;
  localparam logic [7:0]  ATTR_REVERSE   = 8'h04;
  localparam logic [20:0] CODE_NUL   = 21'd0;
  localparam logic [20:0] CODE_SPACE = 21'd32;
  localparam logic [20:0] CODE_PRINT_LO = 21'd33;
  localparam logic [20:0] CODE_PRINT_HI = 21'd126;

  localparam logic [31:0] ANSI16 [16] = '{
    32'hFF000000, 32'hFFCD0000, 32'hFF00CD00, 32'hFFCDCD00,
    32'hFF0000EE, 32'hFFCD00CD, 32'hFF00CDCD, 32'hFFE5E5E5,
    32'hFF7F7F7F, 32'hFFFF0000, 32'hFF00FF00, 32'hFFFFFF00,
    32'hFF5C5CFF, 32'hFFFF00FF, 32'hFF00FFFF, 32'hFFFFFFFF
  };

  // last field in the lowest bits
  typedef struct packed {
    logic [4:0]  offset_y;
    logic [5:0]  offset_x;
    logic [11:0] cell_line;
    logic [11:0] cell_column;
    logic        double_wide;
    logic [7:0]  attr_bits;
    logic [31:0] back_color;
    logic [31:0] fore_color;
    logic [20:0] glyph_code;
  } cell_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] pixel_argb;
    logic [11:0] screen_y;
    logic [11:0] screen_x;
  } pixel_item_t;

  localparam int unsigned IN_ITEM_W  = $bits(cell_item_t);
  localparam int unsigned OUT_ITEM_W = $bits(pixel_item_t);

  function automatic logic [31:0] resolve_colour(input logic [31:0] v);
    logic [7:0]  ix;
    logic [7:0]  k;
    logic [13:0] t36;
    logic [15:0] t6;
    logic [2:0]  r3;
    logic [5:0]  q6;
    logic [5:0]  g6;
    logic [7:0]  b8;
    logic [7:0]  rc;
    logic [7:0]  gc;
    logic [7:0]  bc;
    logic [7:0]  gr;
    ix  = v[7:0];
    k   = ix - 8'd16;
    t36 = {6'b0, k} * 14'd57;
    t6  = {8'b0, k} * 16'd171;
    r3  = t36[13:11];
    q6  = t6[15:10];
    g6  = q6 - ({3'b0, r3} * 6'd6);
    b8  = k - ({2'b0, q6} * 8'd6);
    rc  = {5'b0, r3} * 8'd51;
    gc  = g6[2:0] * 8'd51;
    bc  = b8[2:0] * 8'd51;
    gr  = 8'd8 + ((ix - 8'd232) * 8'd10);
    if ((v & ALPHA_OPAQUE) == ALPHA_OPAQUE) begin
      return v;
    end else if (ix < 8'd16) begin
      return ANSI16[ix[3:0]];
    end else if (ix < 8'd232) begin
      return {8'hFF, rc, gc, bc};
    end else begin
      return {8'hFF, gr, gr, gr};
    end
  endfunction

endpackage

FILE: hdl/text_cell_pixel_generator_top.sv
`timescale 1ns / 1ps

// Channel        Direction  Transfer when               Payload
// s_axis (cell)  in         s_axis_tvalid & tready      one pixel of one cell
// m_axis (pixel) out        m_axis_tvalid & tready      coordinates, colour, enable
// cfg            in         cfg_we_i                    register index and value
//
// One pixel per clock while the output is not stalled.
// Input register, then colour lookup, glyph test and one small multiply per axis,
// then the result register.
// Reset restores the default font and surface sizes and empties both registers.
// A stalled output holds its result; the input register still fills behind it.

module text_cell_pixel_generator_top #(
  parameter int unsigned MAX_FONT_DIM    = 32,
  parameter int unsigned MAX_SURFACE_DIM = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // glyph_code, fore_color, back_color, attr_bits, double_wide,
  // cell_column, cell_line, offset_x, offset_y, zero pad
  input  logic [tcpg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // screen_x, screen_y, pixel_argb, write_enable, zero pad
  output logic [tcpg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we_i,
  input  tcpg_pkg::reg_idx_e                 cfg_index_i,
  input  logic [tcpg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned FW = $clog2(MAX_FONT_DIM + 1);
  localparam int unsigned SW = $clog2(MAX_SURFACE_DIM + 1);
  localparam int unsigned DIM_W = ((FW > 6) ? FW : 6) + 2;
  localparam int unsigned PX_W = 12 + FW + 1;
  localparam int unsigned XC_W = (PX_W > SW) ? PX_W : SW;
  localparam int unsigned FONT_W_RST = (8 > MAX_FONT_DIM) ? MAX_FONT_DIM : 8;
  localparam int unsigned FONT_H_RST = (16 > MAX_FONT_DIM) ? MAX_FONT_DIM : 16;
  localparam int unsigned SURF_W_RST = (640 > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : 640;
  localparam int unsigned SURF_H_RST = (480 > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : 480;

  logic [FW-1:0] font_w_q, font_w_d;
  logic [FW-1:0] font_h_q, font_h_d;
  logic [SW-1:0] surf_w_q, surf_w_d;
  logic [SW-1:0] surf_h_q, surf_h_d;

  logic [5:0]  cfg_font;
  logic [12:0] cfg_surf;
  logic [FW-1:0] cfg_font_sat;
  logic [SW-1:0] cfg_surf_sat;

  assign cfg_font = cfg_data_i[5:0];
  assign cfg_surf = cfg_data_i[12:0];
  assign cfg_font_sat = (32'(cfg_font) > MAX_FONT_DIM) ? FW'(MAX_FONT_DIM) : FW'(cfg_font);
  assign cfg_surf_sat = (32'(cfg_surf) > MAX_SURFACE_DIM) ? SW'(MAX_SURFACE_DIM)
                                                          : SW'(cfg_surf);

  always_comb begin
    font_w_d = font_w_q;
    font_h_d = font_h_q;
    surf_w_d = surf_w_q;
    surf_h_d = surf_h_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcpg_pkg::REG_FONT_WIDTH: begin
          if (cfg_font != 6'd0) font_w_d = cfg_font_sat;
        end
        tcpg_pkg::REG_FONT_HEIGHT: begin
          if (cfg_font != 6'd0) font_h_d = cfg_font_sat;
        end
        tcpg_pkg::REG_SURFACE_WIDTH:  surf_w_d = cfg_surf_sat;
        tcpg_pkg::REG_SURFACE_HEIGHT: surf_h_d = cfg_surf_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_w_q <= FW'(FONT_W_RST);
      font_h_q <= FW'(FONT_H_RST);
      surf_w_q <= SW'(SURF_W_RST);
      surf_h_q <= SW'(SURF_H_RST);
    end else begin
      font_w_q <= font_w_d;
      font_h_q <= font_h_d;
      surf_w_q <= surf_w_d;
      surf_h_q <= surf_h_d;
    end
  end

  logic                  in_valid_q;
  tcpg_pkg::cell_item_t  in_q;
  logic                  out_valid_q;
  tcpg_pkg::pixel_item_t out_q, out_d;
  logic                  out_advance;

  assign out_advance   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= tcpg_pkg::cell_item_t'(s_axis_tdata[tcpg_pkg::IN_ITEM_W-1:0]);
    end
    if (out_advance && in_valid_q) out_q <= out_d;
  end

  logic [DIM_W-1:0] ox_e, oy_e, fw_e, fh_e, cw_e;
  logic [PX_W-1:0]  px, py;
  logic             in_bounds;
  logic [31:0]      fg_raw, bg_raw, fg, bg, colour;
  logic             printable, blank, glyph_hit, glyph_px, underline_px;

  assign ox_e = DIM_W'(in_q.offset_x);
  assign oy_e = DIM_W'(in_q.offset_y);
  assign fw_e = DIM_W'(font_w_q);
  assign fh_e = DIM_W'(font_h_q);
  assign cw_e = in_q.double_wide ? (fw_e << 1) : fw_e;

  assign px = (PX_W'(in_q.cell_column) * PX_W'(font_w_q)) + PX_W'(in_q.offset_x);
  assign py = (PX_W'(in_q.cell_line) * PX_W'(font_h_q)) + PX_W'(in_q.offset_y);

  assign in_bounds = (ox_e < cw_e) && (oy_e < fh_e) &&
                     (XC_W'(px) < XC_W'(surf_w_q)) && (XC_W'(py) < XC_W'(surf_h_q));

  assign fg_raw = tcpg_pkg::resolve_colour(in_q.fore_color);
  assign bg_raw = tcpg_pkg::resolve_colour(in_q.back_color);
  assign fg = ((in_q.attr_bits & tcpg_pkg::ATTR_REVERSE) != 8'd0) ? bg_raw : fg_raw;
  assign bg = ((in_q.attr_bits & tcpg_pkg::ATTR_REVERSE) != 8'd0) ? fg_raw : bg_raw;

  assign blank = (in_q.glyph_code == tcpg_pkg::CODE_NUL) ||
                 (in_q.glyph_code == tcpg_pkg::CODE_SPACE);
  assign printable = (in_q.glyph_code >= tcpg_pkg::CODE_PRINT_LO) &&
                     (in_q.glyph_code <= tcpg_pkg::CODE_PRINT_HI);

  always_comb begin
    if (blank) begin
      glyph_hit = 1'b0;
    end else if (printable) begin
      glyph_hit = !((ox_e == '0) || (ox_e + DIM_W'(1) == fw_e) ||
                    (oy_e == '0) || (oy_e + DIM_W'(1) == fh_e)) &&
                  !(in_q.offset_x[0] ^ in_q.offset_y[0]);
    end else begin
      glyph_hit = (ox_e == DIM_W'(1)) || (ox_e + DIM_W'(2) == fw_e) ||
                  (oy_e == DIM_W'(1)) || (oy_e + DIM_W'(2) == fh_e);
    end
  end

  assign glyph_px = (ox_e < fw_e) && glyph_hit;
  assign underline_px = ((in_q.attr_bits & tcpg_pkg::ATTR_UNDERLINE) != 8'd0) &&
                        (fh_e >= DIM_W'(2)) && (oy_e + DIM_W'(2) == fh_e);
  assign colour = (glyph_px || underline_px) ? fg : bg;

  always_comb begin
    out_d = '0;
    if (in_bounds) begin
      out_d.screen_x     = px[11:0];
      out_d.screen_y     = py[11:0];
      out_d.pixel_argb   = colour;
      out_d.write_enable = 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(tcpg_pkg::OUT_TDATA_W - tcpg_pkg::OUT_ITEM_W){1'b0}}, out_q};

`ifndef NO_ASSERTIONS
  a_font_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (font_w_q != '0) && (font_h_q != '0) &&
    (32'(font_w_q) <= MAX_FONT_DIM) && (32'(font_h_q) <= MAX_FONT_DIM))
    else $error("font size register out of range");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.write_enable) |->
      (out_q.screen_x == '0) && (out_q.screen_y == '0) && (out_q.pixel_argb == '0))
    else $error("clipped pixel carries non-zero fields");

  a_on_surface: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.write_enable) |->
      (XC_W'(out_q.screen_x) < XC_W'(surf_w_q)) && (XC_W'(out_q.screen_y) < XC_W'(surf_h_q)))
    else $error("written pixel lies off the surface");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_advance) |=> out_valid_q)
    else $error("held item did not reach the result register");
`endif

endmodule

FILE: bench/text_cell_pixel_generator_top_tb.sv
`timescale 1ns / 1ps

module text_cell_pixel_generator_top_tb;
  import tcpg_pkg::*;

  localparam int unsigned MAX_FONT    = 32;
  localparam int unsigned MAX_SURF    = 4096;
  localparam int unsigned FIXED_SETS  = 6;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_CELLS = 134;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  reg_idx_e               cfg_index_i = REG_FONT_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // register shadow
  int unsigned font_w = 8;
  int unsigned font_h = 16;
  int unsigned surf_w = 640;
  int unsigned surf_h = 480;

  cell_item_t  cell_queue[$];
  pixel_item_t pixel_expected[$];
  cell_item_t  cell_on_bus;
  int unsigned cells_issued = 0;
  int unsigned pixels_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  bit          burst = 1'b0;

  text_cell_pixel_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // glyph_code, fore_color, back_color, attr_bits, double_wide,
    // cell_column, cell_line, offset_x, offset_y, zero pad
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // screen_x, screen_y, pixel_argb, write_enable, zero pad
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] palette_argb(input logic [31:0] v);
    int unsigned ix;
    int unsigned k;
    int unsigned lvl;
    ix = v[7:0];
    if ((v & ALPHA_OPAQUE) == ALPHA_OPAQUE) return v;
    if (ix < 16) return ANSI16[ix];
    if (ix < 232) begin
      k = ix - 16;
      return {8'hFF, 8'((k / 36) * 51), 8'(((k / 6) % 6) * 51), 8'((k % 6) * 51)};
    end
    lvl = 8 + (ix - 232) * 10;
    return {8'hFF, 8'(lvl), 8'(lvl), 8'(lvl)};
  endfunction

  function automatic bit glyph_lit(input logic [20:0] code, input int x, input int y,
                                   input int fw, input int fh);
    if (code == CODE_NUL || code == CODE_SPACE) return 1'b0;
    if (code >= CODE_PRINT_LO && code <= CODE_PRINT_HI) begin
      if (x == 0 || x == fw - 1 || y == 0 || y == fh - 1) return 1'b0;
      return ((x + y) % 2) == 0;
    end
    return x == 1 || x == fw - 2 || y == 1 || y == fh - 2;
  endfunction

  function automatic pixel_item_t predict_pixel(input cell_item_t c);
    pixel_item_t p;
    int unsigned cw;
    int unsigned px;
    int unsigned py;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [31:0] t;
    p  = '0;
    cw = c.double_wide ? 2 * font_w : font_w;
    px = c.cell_column * font_w + c.offset_x;
    py = c.cell_line * font_h + c.offset_y;
    if (c.offset_x >= cw || c.offset_y >= font_h || px >= surf_w || py >= surf_h) return p;
    fg = palette_argb(c.fore_color);
    bg = palette_argb(c.back_color);
    if ((c.attr_bits & ATTR_REVERSE) != 0) begin
      t  = fg;
      fg = bg;
      bg = t;
    end
    p.pixel_argb = bg;
    if (c.offset_x < font_w &&
        glyph_lit(c.glyph_code, c.offset_x, c.offset_y, font_w, font_h))
      p.pixel_argb = fg;
    if ((c.attr_bits & ATTR_UNDERLINE) != 0 && font_h >= 2 && c.offset_y == font_h - 2)
      p.pixel_argb = fg;
    p.screen_x     = px[11:0];
    p.screen_y     = py[11:0];
    p.write_enable = 1'b1;
    return p;
  endfunction

  function automatic cell_item_t make_cell(input logic [20:0] code, input logic [31:0] fg,
                                           input logic [31:0] bg, input logic [7:0] attr,
                                           input bit wide, input int col, input int line,
                                           input int ox, input int oy);
    cell_item_t c;
    c.glyph_code  = code;
    c.fore_color  = fg;
    c.back_color  = bg;
    c.attr_bits   = attr;
    c.double_wide = wide;
    c.cell_column = 12'(col);
    c.cell_line   = 12'(line);
    c.offset_x    = 6'(ox);
    c.offset_y    = 5'(oy);
    return c;
  endfunction

  function automatic logic [31:0] random_colour();
    case ($urandom_range(0, 3))
      0:       return ALPHA_OPAQUE | ($urandom() & 32'h00FF_FFFF);
      1, 2:    return {$urandom() & 32'h7FFF_FF00} | 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic cell_item_t random_cell();
    cell_item_t  c;
    int unsigned cw;
    int unsigned span_x;
    int unsigned span_y;
    case ($urandom_range(0, 7))
      0:       c.glyph_code = CODE_NUL;
      1:       c.glyph_code = CODE_SPACE;
      2, 3, 4: c.glyph_code = 21'($urandom_range(33, 126));
      5:       c.glyph_code = 21'($urandom_range(0, 255));
      6:       c.glyph_code = 21'($urandom_range(0, 1114111));
      default: c.glyph_code = 21'($urandom_range(127, 1114111));
    endcase
    c.fore_color  = random_colour();
    c.back_color  = random_colour();
    c.attr_bits   = 8'($urandom_range(0, 255));
    c.double_wide = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 8) begin
      cw     = c.double_wide ? 2 * font_w : font_w;
      span_x = (surf_w + font_w - 1) / font_w;
      span_y = (surf_h + font_h - 1) / font_h;
      c.cell_column = 12'((span_x > 4095) ? $urandom_range(0, 4095) : $urandom_range(0, span_x));
      c.cell_line   = 12'((span_y > 4095) ? $urandom_range(0, 4095) : $urandom_range(0, span_y));
      c.offset_x    = 6'($urandom_range(0, cw - 1));
      c.offset_y    = 5'($urandom_range(0, font_h - 1));
      if (font_h >= 2 && $urandom_range(0, 7) == 0) c.offset_y = 5'(font_h - 2);
    end else begin
      c.cell_column = 12'($urandom_range(0, 4095));
      c.cell_line   = 12'($urandom_range(0, 4095));
      c.offset_x    = 6'($urandom_range(0, 63));
      c.offset_y    = 5'($urandom_range(0, 31));
    end
    return c;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    int unsigned v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_FONT_WIDTH, REG_FONT_HEIGHT: begin
        v = val[5:0];
        if (v != 0) begin
          if (v > MAX_FONT) v = MAX_FONT;
          if (idx == REG_FONT_WIDTH) font_w = v;
          else font_h = v;
        end
      end
      default: begin
        v = val;
        if (v > MAX_SURF) v = MAX_SURF;
        if (idx == REG_SURFACE_WIDTH) surf_w = v;
        else surf_h = v;
      end
    endcase
  endtask

  task automatic drain_pixels();
    wait (cell_queue.size() == 0 && pixels_checked == cells_issued);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    mismatches++;
    $display("%0t: %s expected %h got %h", $time, field, want, got);
  endtask

  // source side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pixel_expected.push_back(predict_pixel(cell_on_bus));
        src_gap = burst ? 0 : $urandom_range(0, 4);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          cell_on_bus = cell_queue.pop_front();
          cells_issued++;
          s_axis_tdata  <= {{(IN_TDATA_W - IN_ITEM_W){1'b0}}, cell_on_bus};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t want;
    pixel_item_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = pixel_item_t'(m_axis_tdata[OUT_ITEM_W-1:0]);
        if (pixel_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer %h", $time, m_axis_tdata);
        end else begin
          want = pixel_expected.pop_front();
          pixels_checked++;
          if (got.screen_x !== want.screen_x)
            flag_field("screen_x", 32'(want.screen_x), 32'(got.screen_x));
          if (got.screen_y !== want.screen_y)
            flag_field("screen_y", 32'(want.screen_y), 32'(got.screen_y));
          if (got.pixel_argb !== want.pixel_argb)
            flag_field("pixel_argb", want.pixel_argb, got.pixel_argb);
          if (got.write_enable !== want.write_enable)
            flag_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
        end
        sink_gap = burst ? 0 : $urandom_range(0, 4);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] fixed_sets [FIXED_SETS][4];
    logic [CFG_DATA_W-1:0] vals [4];
    fixed_sets = '{
      '{13'd1, 13'd1, 13'd1, 13'd1},
      '{13'd32, 13'd32, 13'd4096, 13'd4096},
      '{13'd63, 13'd33, 13'd8191, 13'd5000},
      '{13'h1FC0, 13'd0, 13'd0, 13'd100},
      '{13'd2, 13'd2, 13'd37, 13'd23},
      '{13'd5, 13'd9, 13'd200, 13'd150}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default sizes after reset: 8x16 font, 640x480 surface
    cell_queue.push_back(make_cell(CODE_NUL, 32'hFFFFFFFF, 32'h0, 8'h00, 0, 0, 0, 3, 3));
    cell_queue.push_back(make_cell(CODE_SPACE, 32'hFFFFFFFF, 32'h0, 8'h00, 0, 1, 0, 3, 3));
    cell_queue.push_back(make_cell(21'd65, 32'h01, 32'h0F, 8'h00, 0, 2, 0, 2, 2));
    cell_queue.push_back(make_cell(21'd65, 32'h01, 32'h0F, 8'h00, 0, 2, 0, 3, 2));
    cell_queue.push_back(make_cell(21'd65, 32'h01, 32'h0F, 8'h00, 0, 2, 0, 0, 5));
    cell_queue.push_back(make_cell(CODE_PRINT_HI, 32'h09, 32'h04, 8'h00, 0, 3, 1, 7, 15));
    cell_queue.push_back(make_cell(CODE_PRINT_LO, 32'h0C, 32'h07, ATTR_UNDERLINE, 0, 4, 1,
                                   4, 14));
    cell_queue.push_back(make_cell(21'd127, 32'd16, 32'd231, 8'h00, 0, 5, 2, 1, 8));
    cell_queue.push_back(make_cell(21'h10FFFF, 32'd232, 32'd255, 8'h00, 0, 6, 2, 6, 7));
    cell_queue.push_back(make_cell(21'h2500, 32'hFF102030, 32'd100, ATTR_REVERSE, 0, 7, 3,
                                   3, 3));
    cell_queue.push_back(make_cell(21'd65, 32'd200, 32'd250, 8'hFF, 0, 8, 3, 5, 14));
    cell_queue.push_back(make_cell(21'h4E00, 32'd1, 32'd2, 8'h00, 1, 9, 4, 9, 1));
    cell_queue.push_back(make_cell(21'h4E00, 32'd3, 32'd4, ATTR_UNDERLINE, 1, 10, 4, 15, 14));
    cell_queue.push_back(make_cell(21'h4E00, 32'd5, 32'd6, 8'h00, 1, 11, 4, 16, 2));
    cell_queue.push_back(make_cell(21'd66, 32'd5, 32'd6, 8'h00, 0, 12, 4, 8, 2));
    cell_queue.push_back(make_cell(21'd66, 32'd5, 32'd6, 8'h00, 0, 12, 4, 2, 16));
    cell_queue.push_back(make_cell(21'd66, 32'd5, 32'd6, 8'h00, 1, 12, 4, 63, 31));
    cell_queue.push_back(make_cell(21'd127, 32'hFFABCDEF, 32'd240, 8'h00, 0, 79, 29, 7, 15));
    cell_queue.push_back(make_cell(21'd67, 32'd7, 32'd8, 8'h00, 0, 80, 0, 0, 0));
    cell_queue.push_back(make_cell(21'd67, 32'd7, 32'd8, 8'h00, 0, 0, 30, 0, 0));
    cell_queue.push_back(make_cell(21'd67, 32'd7, 32'd8, 8'h00, 1, 4095, 4095, 0, 0));
    cell_queue.push_back(make_cell(21'd68, 32'hFE123456, 32'h12345678, 8'h00, 0, 13, 5,
                                   4, 4));
    drain_pixels();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 4; r++) begin
        if (ph < FIXED_SETS) vals[r] = fixed_sets[ph][r];
        else if (r < 2) vals[r] = CFG_DATA_W'($urandom_range(1, MAX_FONT));
        else if ($urandom_range(0, 3) == 0) vals[r] = CFG_DATA_W'($urandom_range(0, 8191));
        else vals[r] = CFG_DATA_W'($urandom_range(1, MAX_SURF));
      end
      for (int r = 0; r < 4; r++) write_reg(reg_idx_e'(r), vals[r]);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_CELLS; n++) cell_queue.push_back(random_cell());
      drain_pixels();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pixel_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
